// ----- sv/tab_pkg.sv -----
package tab_pkg;

  // table size and field widths
  localparam int ENTRIES     = 16;
  localparam int ADDR_W      = 32;
  localparam int TICK_W      = 32;
  localparam int DURATION_W  = 16;
  localparam int MODE_W      = 2;

  localparam logic [DURATION_W-1:0] BLOCK_TICKS_RESET = DURATION_W'(60);

  // item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLOCK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic blocked;
    logic table_full;
  } out_t;

  // item as it travels from cell to cell
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [TICK_W-1:0] now;
    logic              placed;
    logic              hit;
  } beat_t;

endpackage

// ----- sv/tab_cell.sv -----
module tab_cell
  import tab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [DURATION_W-1:0] block_ticks,
  input  beat_t                 prev,
  output beat_t                 next
);

  // slot held by this cell
  logic              live;
  logic [ADDR_W-1:0] address;
  logic [TICK_W-1:0] start;

  logic [TICK_W-1:0] elapsed;
  logic              live_eff;
  logic              take;
  logic              match;
  beat_t             next_next;

  // expiry against the time the item carries
  always_comb begin
    elapsed  = prev.now - start;
    live_eff = live && (elapsed < TICK_W'(block_ticks));
    take     = prev.valid && (prev.mode == MODE_BLOCK) && !prev.placed && !live_eff;
    match    = (prev.mode == MODE_QUERY) && live_eff && (address == prev.address);
  end

  // forward the item with updated flags
  always_comb begin
    next_next        = prev;
    next_next.placed = prev.placed || take;
    next_next.hit    = prev.hit || match;
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (advance && prev.valid) begin
      live <= live_eff || take;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      address <= prev.address;
      start   <= prev.now;
    end
  end

  // stage register toward the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      next <= '0;
    end else if (advance) begin
      next <= next_next;
    end
  end

endmodule

// ----- sv/timed_address_blocklist.sv -----
// aging blocklist of ipv4 addresses, one table slot per cell
//
// input channel in_valid/in_ready/in_data carries one item per beat: a tick
// (advance time), a block (store the address) or a query (look it up).
// output channel out_valid/out_ready/out_data returns exactly one result
// beat per item, in order: blocked for queries, table_full for dropped blocks.
// write block_ticks (cfg_we/cfg_data) only with no item in flight; unchecked.
//
// each item walks the row of ENTRIES cells, one cell per clock while the row
// advances, expiring, inserting and matching as it passes. the result is on
// out_data once the item leaves the last cell. items can follow one another
// every cycle, so throughput is one item per cycle unless a stalled result
// holds the row; the row length sets the latency.
//
// reset empties the table, clears time to zero and sets block_ticks to 60.
// when the receiver stalls with a result waiting, the whole row holds and
// in_ready drops until that result is taken.
module timed_address_blocklist
  import tab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [DURATION_W-1:0] cfg_data
);

  logic [DURATION_W-1:0] block_ticks;
  logic [TICK_W-1:0]     now_ticks;
  logic [TICK_W-1:0]     now_ticks_next;
  logic                  advance;
  logic                  accept;
  beat_t                 chain [0:ENTRIES];

  // row moves unless a finished result is stalled
  assign advance  = !chain[ENTRIES].valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_ticks <= BLOCK_TICKS_RESET;
    end else if (cfg_we) begin
      block_ticks <= cfg_data;
    end
  end

  // time counter, a tick counts before its own expiry
  always_comb begin
    now_ticks_next = now_ticks;
    if (in_data.mode == MODE_TICK) begin
      now_ticks_next = now_ticks + TICK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
    end else if (accept) begin
      now_ticks <= now_ticks_next;
    end
  end

  // head of the row
  always_comb begin
    chain[0].valid   = accept;
    chain[0].mode    = in_data.mode;
    chain[0].address = in_data.address;
    chain[0].now     = now_ticks_next;
    chain[0].placed  = 1'b0;
    chain[0].hit     = 1'b0;
  end

  // row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tab_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .block_ticks (block_ticks),
      .prev        (chain[i]),
      .next        (chain[i+1])
    );
  end

  // result from the tail
  assign out_valid           = chain[ENTRIES].valid;
  assign out_data.blocked    = chain[ENTRIES].hit;
  assign out_data.table_full = (chain[ENTRIES].mode == MODE_BLOCK) && !chain[ENTRIES].placed;

endmodule

// ----- sv/tab_checker.sv -----
module tab_checker
  import tab_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  // a result never reports both a hit and a dropped insert
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.blocked && out_data.table_full))
    else $error("blocked and table_full both set");

  // with free flow the row stays ready
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready with no result waiting");

endmodule

bind timed_address_blocklist tab_checker u_tab_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb_timed_address_blocklist.sv -----
module tb_timed_address_blocklist;
  import tab_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // mode value the block does not define: expiry only, no time step
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int HOT_COUNT   = 8;
  localparam int CYCLE_LIMIT = 300000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [DURATION_W-1:0] cfg_data = '0;

  // shadow of the blocklist
  logic [DURATION_W-1:0] hold_ticks;
  logic [TICK_W-1:0]     tick_count;
  logic [ADDR_W-1:0]     slot_addr [ENTRIES];
  logic [TICK_W-1:0]     slot_stamp [ENTRIES];
  logic                  slot_live [ENTRIES];

  out_t              pending_verdicts[$];
  logic [ADDR_W-1:0] hot_addr [HOT_COUNT];
  int                mismatches = 0;
  int                cycles = 0;
  bit                steady = 1'b0;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  row_t opening_rows[$];

  timed_address_blocklist i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL timed_address_blocklist");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 23);
    end
  end

  // compare each result beat with the oldest predicted verdict
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat: expected none, got blocked=%0b full=%0b",
                 $time, out_data.blocked, out_data.table_full);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.blocked !== want.blocked) begin
          mismatches++;
          $display("%0t blocked mismatch: expected %0b, got %0b",
                   $time, want.blocked, out_data.blocked);
        end
        if (out_data.table_full !== want.table_full) begin
          mismatches++;
          $display("%0t table_full mismatch: expected %0b, got %0b",
                   $time, want.table_full, out_data.table_full);
        end
      end
    end
  end

  function automatic void clear_blocklist();
    hold_ticks = BLOCK_TICKS_RESET;
    tick_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_addr[i]  = '0;
      slot_stamp[i] = '0;
      slot_live[i]  = 1'b0;
    end
  endfunction

  // one item through the shadow table: time step, expiry, then insert or lookup
  function automatic out_t advance_blocklist(in_t it);
    out_t              verdict;
    logic [TICK_W-1:0] age;
    bit                placed;
    verdict = '0;
    placed  = 1'b0;
    if (it.mode == MODE_TICK) begin
      tick_count = tick_count + 1'b1;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      age = tick_count - slot_stamp[i];
      if (slot_live[i] && age >= TICK_W'(hold_ticks)) begin
        slot_live[i] = 1'b0;
      end
    end
    if (it.mode == MODE_BLOCK) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!placed && !slot_live[i]) begin
          slot_live[i]  = 1'b1;
          slot_addr[i]  = it.address;
          slot_stamp[i] = tick_count;
          placed        = 1'b1;
        end
      end
      verdict.table_full = !placed;
    end else if (it.mode == MODE_QUERY) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_live[i] && slot_addr[i] == it.address) begin
          verdict.blocked = 1'b1;
        end
      end
    end
    return verdict;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] address,
                                  bit typed, logic blocked, logic full);
    row_t r;
    r.item.mode         = mode;
    r.item.address      = address;
    r.typed             = typed;
    r.want.blocked      = blocked;
    r.want.table_full   = full;
    opening_rows.push_back(r);
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.mode = MODE_TICK;
    end else if (pick < 60) begin
      it.mode = MODE_BLOCK;
    end else if (pick < 95) begin
      it.mode = MODE_QUERY;
    end else begin
      it.mode = MODE_SPARE;
    end
    if ($urandom_range(9) < 7) begin
      it.address = hot_addr[$urandom_range(HOT_COUNT-1)];
    end else begin
      it.address = $urandom;
    end
    return it;
  endfunction

  // present one input beat, with random idle cycles ahead of it
  task automatic send_beat(input in_t it, input bit typed, input out_t want);
    out_t predicted;
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_blocklist(it);
    pending_verdicts.push_back(typed ? want : predicted);
  endtask

  // hold off the sender until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_hold_ticks(input logic [DURATION_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    hold_ticks = value;
  endtask

  task automatic run_phase(input logic [DURATION_W-1:0] value, input int count,
                           input bit pause_midway);
    set_hold_ticks(value);
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) begin
        drain();
      end
      send_beat(random_item(), 1'b0, '0);
    end
  endtask

  initial begin
    clear_blocklist();
    hot_addr[0] = '0;
    hot_addr[1] = '1;
    for (int i = 2; i < HOT_COUNT; i++) begin
      hot_addr[i] = $urandom;
    end

    // directed opening: empty table, extremes, duplicates, spare mode, overflow
    add_row(MODE_QUERY, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_row(MODE_QUERY, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(MODE_BLOCK, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_row(MODE_BLOCK, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(MODE_QUERY, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    add_row(MODE_TICK,  32'h1234_5678, 1'b1, 1'b0, 1'b0);
    add_row(MODE_SPARE, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0);
    add_row(MODE_QUERY, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
    add_row(MODE_BLOCK, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < ENTRIES - 3; i++) begin
      add_row(MODE_BLOCK, 32'h0A00_0001 + i, 1'b0, 1'b0, 1'b0);
    end
    add_row(MODE_BLOCK, 32'h5555_5555, 1'b1, 1'b0, 1'b1);
    add_row(MODE_QUERY, 32'h5555_5555, 1'b1, 1'b0, 1'b0);
    add_row(MODE_TICK,  32'h0000_0000, 1'b1, 1'b0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[k]) begin
      send_beat(opening_rows[k].item, opening_rows[k].typed, opening_rows[k].want);
    end

    // random phases across hold times, extremes included
    run_phase(DURATION_W'(1), 150, 1'b0);
    run_phase(DURATION_W'(0), 120, 1'b0);
    run_phase(DURATION_W'(65535), 150, 1'b0);
    run_phase(DURATION_W'(12), 150, 1'b1);
    steady = 1'b1;
    run_phase(DURATION_W'(5), 150, 1'b0);
    steady = 1'b0;
    run_phase(DURATION_W'($urandom_range(40, 2)), 150, 1'b0);
    run_phase(BLOCK_TICKS_RESET, 130, 1'b0);

    drain();
    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS timed_address_blocklist");
    end else begin
      $display("FAIL timed_address_blocklist");
    end
    $finish;
  end

endmodule
